// File: rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants of the lazy range set/add, sum/min/max tree:
// sizes, command codes, node word layout and shared unit request.
// ----------------------------------------------------------------------------
package lrs_pkg;

  // sizes
  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = 10;
  localparam int LEN_W        = 11;
  localparam int DATA_W       = 64;
  localparam int NODE_AW      = $clog2(MAX_ELEMENTS) + 1;
  localparam int NODE_DEPTH   = 1 << NODE_AW;
  localparam int STK_AW       = $clog2(NODE_AW);
  localparam int STK_DEPTH    = 1 << STK_AW;

  // empty-range identities
  localparam logic [DATA_W-1:0] BIG_VALUE     = 64'd2000000000000000000;
  localparam logic [DATA_W-1:0] NEG_BIG_VALUE = ~BIG_VALUE + 64'd1;

  // command codes
  localparam logic [1:0] CMD_ASSIGN = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // shared unit operations
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_MUL = 2'd1,
    ALU_MIN = 2'd2,
    ALU_MAX = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
    logic [LEN_W-1:0]    cnt;
  } alu_req_t;

  // one tree node as stored in the node memory
  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] mn;
    logic [DATA_W-1:0] mx;
    logic [DATA_W-1:0] add;
    logic [DATA_W-1:0] asg;
    logic              flag;
  } node_t;

  // walk frame phases
  typedef enum logic [1:0] {
    PH_ENTER = 2'd0,
    PH_RIGHT = 2'd1,
    PH_PULL  = 2'd2
  } ph_t;

  typedef struct packed {
    logic [NODE_AW-1:0] node;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    ph_t                ph;
  } frame_t;

  // where a tag application returns to
  typedef enum logic [1:0] {
    RET_POP      = 2'd0,
    RET_PD_RIGHT = 2'd1,
    RET_PD_DONE  = 2'd2
  } ret_t;

endpackage

// File: rtl/lrs_in_if.sv
// ----------------------------------------------------------------------------
// lrs_in_if
// Command channel: valid/ready word with command, index range and operand.
// ----------------------------------------------------------------------------
interface lrs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [9:0]         first_index;
  logic [9:0]         last_index;
  logic signed [63:0] operand_value;

  modport source (output valid, command, first_index, last_index, operand_value,
                  input ready);
  modport sink   (input valid, command, first_index, last_index, operand_value,
                  output ready);
endinterface

// File: rtl/lrs_out_if.sv
// ----------------------------------------------------------------------------
// lrs_out_if
// Result channel: valid/ready word with range sum, min, max and empty flag.
// ----------------------------------------------------------------------------
interface lrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] range_sum;
  logic signed [63:0] range_min;
  logic signed [63:0] range_max;
  logic               range_empty;

  modport source (output valid, range_sum, range_min, range_max, range_empty,
                  input ready);
  modport sink   (input valid, range_sum, range_min, range_max, range_empty,
                  output ready);
endinterface

// File: rtl/lrs_alu.sv
// ----------------------------------------------------------------------------
// lrs_alu
// Shared arithmetic unit: wrapping add, span count times value, signed min
// and signed max. One operation per cycle, result registered by the caller.
// ----------------------------------------------------------------------------
module lrs_alu (
  input  lrs_pkg::alu_req_t              req,
  output logic [lrs_pkg::DATA_W-1:0]     y
);

  logic [lrs_pkg::DATA_W+lrs_pkg::LEN_W-1:0] prod;

  // count times value, low word kept
  assign prod = {{lrs_pkg::LEN_W{1'b0}}, req.b} * {{lrs_pkg::DATA_W{1'b0}}, req.cnt};

  // operation select
  always_comb begin
    case (req.op)
      lrs_pkg::ALU_ADD: y = req.a + req.b;
      lrs_pkg::ALU_MUL: y = prod[lrs_pkg::DATA_W-1:0];
      lrs_pkg::ALU_MIN: y = ($signed(req.b) < $signed(req.a)) ? req.b : req.a;
      lrs_pkg::ALU_MAX: y = ($signed(req.a) < $signed(req.b)) ? req.b : req.a;
      default:          y = req.a;
    endcase
  end

endmodule

// File: rtl/lrs_node_ram.sv
// ----------------------------------------------------------------------------
// lrs_node_ram
// Node memory of the tree: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module lrs_node_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [lrs_pkg::NODE_AW-1:0]   waddr,
  input  lrs_pkg::node_t                wdata,
  input  logic [lrs_pkg::NODE_AW-1:0]   raddr,
  output lrs_pkg::node_t                rdata
);

  lrs_pkg::node_t mem_r [lrs_pkg::NODE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/lazy_range_set_add_sum_min_max_top.sv
// ----------------------------------------------------------------------------
// lazy_range_set_add_sum_min_max_top
// Lazy segment tree over signed 64-bit elements: range assign, range add and
// range query of sum, min and max, walked by a small sequencer.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and is not ready until its tree
// walk is done. The walk visits each touched node with a stack of frames;
// every node is visited once (three visits for a node that is split), and
// each visit adds its node memory reads and the steps of the one shared
// arithmetic unit: a covered assign, a covered add, a query hit, a disjoint
// part of a query, a pull-up and a push-down each take their own sequence of
// states. How long a command takes grows with the width of its range and the
// depth of the tree; the node memory and the single shared unit set this.
// After reset and after every cfg_we length write the node memory is cleared
// in a pass over all 2048 node words, during which no command word is taken.
// A query result waits in an output register, so the next command can be
// taken while it is still pending.
// ----------------------------------------------------------------------------
module lazy_range_set_add_sum_min_max_top (
  input  logic                         clk,
  input  logic                         rst_n,
  lrs_in_if.sink                       in_ch,
  lrs_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [lrs_pkg::LEN_W-1:0]    cfg_wdata
);

  localparam int DW  = lrs_pkg::DATA_W;
  localparam int AW  = lrs_pkg::NODE_AW;
  localparam int IW  = lrs_pkg::IDX_W;
  localparam int LW  = lrs_pkg::LEN_W;
  localparam int SW  = lrs_pkg::STK_AW;

  typedef enum logic [20:0] {
    S_CLEAR  = 21'b000000000000000000001,
    S_IDLE   = 21'b000000000000000000010,
    S_VISIT  = 21'b000000000000000000100,
    S_APPLY  = 21'b000000000000000001000,
    S_AD_MUL = 21'b000000000000000010000,
    S_AD_SUM = 21'b000000000000000100000,
    S_AD_MIN = 21'b000000000000001000000,
    S_AD_MAX = 21'b000000000000010000000,
    S_AD_TAG = 21'b000000000000100000000,
    S_PD_RD  = 21'b000000000001000000000,
    S_PD_CLR = 21'b000000000010000000000,
    S_Q_RD   = 21'b000000000100000000000,
    S_Q_SUM  = 21'b000000001000000000000,
    S_Q_MIN  = 21'b000000010000000000000,
    S_Q_MAX  = 21'b000000100000000000000,
    S_PU_RA  = 21'b000001000000000000000,
    S_PU_RB  = 21'b000010000000000000000,
    S_PU_SUM = 21'b000100000000000000000,
    S_PU_MIN = 21'b001000000000000000000,
    S_PU_MAX = 21'b010000000000000000000,
    S_FINISH = 21'b100000000000000000000
  } state_t;

  state_t              state_r, state_nxt;
  lrs_pkg::frame_t     cur_r, cur_nxt;
  logic [SW-1:0]       sp_r, sp_nxt;
  lrs_pkg::frame_t     stk_r [lrs_pkg::STK_DEPTH];
  logic                stk_we;
  lrs_pkg::frame_t     stk_wdata;

  logic [1:0]          cmd_r, cmd_nxt;
  logic [IW-1:0]       first_r, first_nxt;
  logic [IW-1:0]       last_r, last_nxt;
  logic [DW-1:0]       opv_r, opv_nxt;
  logic [IW-1:0]       top_r, top_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;

  logic [DW-1:0]       acc_sum_r, acc_sum_nxt;
  logic [DW-1:0]       acc_min_r, acc_min_nxt;
  logic [DW-1:0]       acc_max_r, acc_max_nxt;
  lrs_pkg::node_t      w_r, w_nxt;
  lrs_pkg::node_t      pw_r, pw_nxt;
  logic [DW-1:0]       tmp_r, tmp_nxt;

  logic [AW-1:0]       ap_addr_r, ap_addr_nxt;
  logic [LW-1:0]       ap_cnt_r, ap_cnt_nxt;
  logic [DW-1:0]       ap_val_r, ap_val_nxt;
  logic                ap_add_r, ap_add_nxt;
  lrs_pkg::ret_t       ret_r, ret_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DW-1:0]       out_sum_r, out_sum_nxt;
  logic [DW-1:0]       out_min_r, out_min_nxt;
  logic [DW-1:0]       out_max_r, out_max_nxt;
  logic                out_empty_r, out_empty_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  lrs_pkg::node_t      mem_wdata;
  logic [AW-1:0]       mem_raddr;
  lrs_pkg::node_t      mem_rdata;

  lrs_pkg::alu_req_t   alu_req;
  logic [DW-1:0]       alu_y;

  logic [LW-1:0]       mid_sum;
  logic [IW-1:0]       mid;
  logic [LW-1:0]       cur_cnt, lcnt, rcnt;
  logic [AW-1:0]       lchild, rchild;
  logic                disjoint, covered, is_query;
  logic                do_ret, do_pop, do_desc;
  logic [LW-1:0]       len_clamp;

  // node memory and shared unit
  lrs_node_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lrs_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // current frame geometry
  assign mid_sum  = {1'b0, cur_r.lo} + {1'b0, cur_r.hi};
  assign mid      = mid_sum[LW-1:1];
  assign cur_cnt  = {1'b0, cur_r.hi} - {1'b0, cur_r.lo} + LW'(1);
  assign lcnt     = {1'b0, mid} - {1'b0, cur_r.lo} + LW'(1);
  assign rcnt     = {1'b0, cur_r.hi} - {1'b0, mid};
  assign lchild   = {cur_r.node[AW-2:0], 1'b0};
  assign rchild   = {cur_r.node[AW-2:0], 1'b1};
  assign disjoint = (first_r > last_r) || (cur_r.lo > last_r) || (cur_r.hi < first_r);
  assign covered  = (cur_r.lo >= first_r) && (cur_r.hi <= last_r);
  assign is_query = (cmd_r == lrs_pkg::CMD_QUERY);

  // length write clamp
  always_comb begin
    if (cfg_wdata == '0) begin
      len_clamp = LW'(1);
    end else if (cfg_wdata > LW'(lrs_pkg::MAX_ELEMENTS)) begin
      len_clamp = LW'(lrs_pkg::MAX_ELEMENTS);
    end else begin
      len_clamp = cfg_wdata;
    end
  end

  // ports
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.range_sum   = $signed(out_sum_r);
  assign out_ch.range_min   = $signed(out_min_r);
  assign out_ch.range_max   = $signed(out_max_r);
  assign out_ch.range_empty = out_empty_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    sp_nxt        = sp_r;
    stk_we        = 1'b0;
    stk_wdata     = cur_r;
    cmd_nxt       = cmd_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    opv_nxt       = opv_r;
    top_nxt       = top_r;
    clr_nxt       = clr_r;
    acc_sum_nxt   = acc_sum_r;
    acc_min_nxt   = acc_min_r;
    acc_max_nxt   = acc_max_r;
    w_nxt         = w_r;
    pw_nxt        = pw_r;
    tmp_nxt       = tmp_r;
    ap_addr_nxt   = ap_addr_r;
    ap_cnt_nxt    = ap_cnt_r;
    ap_val_nxt    = ap_val_r;
    ap_add_nxt    = ap_add_r;
    ret_nxt       = ret_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sum_nxt   = out_sum_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_empty_nxt = out_empty_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r.node;
    mem_wdata     = w_r;
    mem_raddr     = cur_r.node;
    alu_req.op    = lrs_pkg::ALU_ADD;
    alu_req.a     = w_r.sum;
    alu_req.b     = tmp_r;
    alu_req.cnt   = ap_cnt_r;
    do_ret        = 1'b0;
    do_pop        = 1'b0;
    do_desc       = 1'b0;

    case (state_r)
      // zero the node memory
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(lrs_pkg::NODE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // take a command word
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt     = in_ch.command;
          first_nxt   = in_ch.first_index;
          last_nxt    = in_ch.last_index;
          opv_nxt     = unsigned'(in_ch.operand_value);
          cur_nxt     = '{node: AW'(1), lo: '0, hi: top_r, ph: lrs_pkg::PH_ENTER};
          sp_nxt      = '0;
          acc_sum_nxt = '0;
          // neutral start for signed min and max
          acc_min_nxt = {1'b0, {(DW-1){1'b1}}};
          acc_max_nxt = {1'b1, {(DW-1){1'b0}}};
          if (in_ch.command inside {lrs_pkg::CMD_ASSIGN, lrs_pkg::CMD_ADD,
                                    lrs_pkg::CMD_QUERY}) begin
            state_nxt = S_VISIT;
          end
        end
      end

      // dispatch on the current frame
      S_VISIT: begin
        case (cur_r.ph)
          lrs_pkg::PH_ENTER: begin
            if (disjoint && is_query) begin
              // a disjoint part still folds in the empty-range values
              w_nxt     = '{sum: '0, mn: lrs_pkg::BIG_VALUE, mx: lrs_pkg::NEG_BIG_VALUE,
                            add: '0, asg: '0, flag: 1'b0};
              state_nxt = S_Q_SUM;
            end else if (disjoint) begin
              do_pop = 1'b1;
            end else if (covered && is_query) begin
              state_nxt = S_Q_RD;
            end else if (covered) begin
              ap_addr_nxt = cur_r.node;
              ap_cnt_nxt  = cur_cnt;
              ap_val_nxt  = opv_r;
              ap_add_nxt  = (cmd_r == lrs_pkg::CMD_ADD);
              ret_nxt     = lrs_pkg::RET_POP;
              state_nxt   = S_APPLY;
            end else begin
              state_nxt = S_PD_RD;
            end
          end
          lrs_pkg::PH_RIGHT: begin
            stk_we    = 1'b1;
            stk_wdata = '{node: cur_r.node, lo: cur_r.lo, hi: cur_r.hi,
                          ph: lrs_pkg::PH_PULL};
            sp_nxt    = sp_r + SW'(1);
            cur_nxt   = '{node: rchild, lo: mid + IW'(1), hi: cur_r.hi,
                          ph: lrs_pkg::PH_ENTER};
          end
          lrs_pkg::PH_PULL: begin
            if (is_query) begin
              do_pop = 1'b1;
            end else begin
              mem_raddr = lchild;
              state_nxt = S_PU_RA;
            end
          end
          default: do_pop = 1'b1;
        endcase
      end

      // apply an assign or add tag to one node
      S_APPLY: begin
        if (ap_add_r) begin
          mem_raddr = ap_addr_r;
          state_nxt = S_AD_MUL;
        end else begin
          alu_req.op  = lrs_pkg::ALU_MUL;
          alu_req.b   = ap_val_r;
          mem_we      = 1'b1;
          mem_waddr   = ap_addr_r;
          mem_wdata   = '{sum: alu_y, mn: ap_val_r, mx: ap_val_r, add: '0,
                          asg: ap_val_r, flag: 1'b1};
          do_ret      = 1'b1;
        end
      end
      S_AD_MUL: begin
        w_nxt      = mem_rdata;
        alu_req.op = lrs_pkg::ALU_MUL;
        alu_req.b  = ap_val_r;
        tmp_nxt    = alu_y;
        state_nxt  = S_AD_SUM;
      end
      S_AD_SUM: begin
        w_nxt.sum = alu_y;
        state_nxt = S_AD_MIN;
      end
      S_AD_MIN: begin
        alu_req.a = w_r.mn;
        alu_req.b = ap_val_r;
        w_nxt.mn  = alu_y;
        state_nxt = S_AD_MAX;
      end
      S_AD_MAX: begin
        alu_req.a = w_r.mx;
        alu_req.b = ap_val_r;
        w_nxt.mx  = alu_y;
        state_nxt = S_AD_TAG;
      end
      S_AD_TAG: begin
        alu_req.a = w_r.flag ? w_r.asg : w_r.add;
        alu_req.b = ap_val_r;
        mem_we    = 1'b1;
        mem_waddr = ap_addr_r;
        mem_wdata = '{sum: w_r.sum, mn: w_r.mn, mx: w_r.mx,
                      add: w_r.flag ? w_r.add : alu_y,
                      asg: w_r.flag ? alu_y : w_r.asg, flag: w_r.flag};
        do_ret    = 1'b1;
      end

      // push pending tags down to the children
      S_PD_RD: begin
        pw_nxt      = mem_rdata;
        ap_addr_nxt = lchild;
        ap_cnt_nxt  = lcnt;
        ret_nxt     = lrs_pkg::RET_PD_RIGHT;
        if (mem_rdata.flag) begin
          ap_add_nxt = 1'b0;
          ap_val_nxt = mem_rdata.asg;
          state_nxt  = S_APPLY;
        end else if (mem_rdata.add != '0) begin
          ap_add_nxt = 1'b1;
          ap_val_nxt = mem_rdata.add;
          state_nxt  = S_APPLY;
        end else begin
          do_desc = 1'b1;
        end
      end
      S_PD_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '{sum: pw_r.sum, mn: pw_r.mn, mx: pw_r.mx, add: '0,
                      asg: pw_r.asg, flag: 1'b0};
        do_desc   = 1'b1;
      end

      // fold a covered node into the query result
      S_Q_RD: begin
        w_nxt     = mem_rdata;
        state_nxt = S_Q_SUM;
      end
      S_Q_SUM: begin
        alu_req.a   = acc_sum_r;
        alu_req.b   = w_r.sum;
        acc_sum_nxt = alu_y;
        state_nxt   = S_Q_MIN;
      end
      S_Q_MIN: begin
        alu_req.op  = lrs_pkg::ALU_MIN;
        alu_req.a   = acc_min_r;
        alu_req.b   = w_r.mn;
        acc_min_nxt = alu_y;
        state_nxt   = S_Q_MAX;
      end
      S_Q_MAX: begin
        alu_req.op  = lrs_pkg::ALU_MAX;
        alu_req.a   = acc_max_r;
        alu_req.b   = w_r.mx;
        acc_max_nxt = alu_y;
        do_pop      = 1'b1;
      end

      // rebuild a node from its children
      S_PU_RA: begin
        w_nxt     = mem_rdata;
        mem_raddr = rchild;
        state_nxt = S_PU_RB;
      end
      S_PU_RB: begin
        pw_nxt    = mem_rdata;
        state_nxt = S_PU_SUM;
      end
      S_PU_SUM: begin
        alu_req.b = pw_r.sum;
        w_nxt.sum = alu_y;
        state_nxt = S_PU_MIN;
      end
      S_PU_MIN: begin
        alu_req.op = lrs_pkg::ALU_MIN;
        alu_req.a  = w_r.mn;
        alu_req.b  = pw_r.mn;
        w_nxt.mn   = alu_y;
        state_nxt  = S_PU_MAX;
      end
      S_PU_MAX: begin
        alu_req.op = lrs_pkg::ALU_MAX;
        alu_req.a  = w_r.mx;
        alu_req.b  = pw_r.mx;
        mem_we     = 1'b1;
        mem_wdata  = '{sum: w_r.sum, mn: w_r.mn, mx: alu_y, add: '0, asg: '0,
                       flag: 1'b0};
        do_pop     = 1'b1;
      end

      // hand the query result to the output register
      S_FINISH: begin
        if (!is_query) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_sum_r;
          out_min_nxt   = acc_min_r;
          out_max_nxt   = acc_max_r;
          out_empty_nxt = (first_r > last_r) || (first_r > top_r);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_CLEAR;
    endcase

    // return from a tag application
    if (do_ret) begin
      case (ret_r)
        lrs_pkg::RET_POP: do_pop = 1'b1;
        lrs_pkg::RET_PD_RIGHT: begin
          ap_addr_nxt = rchild;
          ap_cnt_nxt  = rcnt;
          ret_nxt     = lrs_pkg::RET_PD_DONE;
          state_nxt   = S_APPLY;
        end
        lrs_pkg::RET_PD_DONE: state_nxt = S_PD_CLR;
        default: do_pop = 1'b1;
      endcase
    end

    // descend into the left child
    if (do_desc) begin
      stk_we    = 1'b1;
      stk_wdata = '{node: cur_r.node, lo: cur_r.lo, hi: cur_r.hi,
                    ph: lrs_pkg::PH_RIGHT};
      sp_nxt    = sp_r + SW'(1);
      cur_nxt   = '{node: lchild, lo: cur_r.lo, hi: mid, ph: lrs_pkg::PH_ENTER};
      state_nxt = S_VISIT;
    end

    // back to the parent frame
    if (do_pop) begin
      if (sp_r == '0) begin
        state_nxt = S_FINISH;
      end else begin
        cur_nxt   = stk_r[sp_r - SW'(1)];
        sp_nxt    = sp_r - SW'(1);
        state_nxt = S_VISIT;
      end
    end

    // length write restarts the tree
    if (cfg_we) begin
      top_nxt   = IW'(len_clamp - LW'(1));
      clr_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  // frame stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_r[sp_r] <= stk_wdata;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      sp_r        <= '0;
      top_r       <= IW'(lrs_pkg::MAX_ELEMENTS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    cmd_r       <= cmd_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    opv_r       <= opv_nxt;
    acc_sum_r   <= acc_sum_nxt;
    acc_min_r   <= acc_min_nxt;
    acc_max_r   <= acc_max_nxt;
    w_r         <= w_nxt;
    pw_r        <= pw_nxt;
    tmp_r       <= tmp_nxt;
    ap_addr_r   <= ap_addr_nxt;
    ap_cnt_r    <= ap_cnt_nxt;
    ap_val_r    <= ap_val_nxt;
    ap_add_r    <= ap_add_nxt;
    ret_r       <= ret_nxt;
    out_sum_r   <= out_sum_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule
